// ----- src/vrt_pkg.sv -----
`timescale 1ns / 1ps

package vrt_pkg;

   // Grid geometry. Every index, row and store width follows from MAX_DIM.
   localparam int MAX_DIM = 32;
   localparam int CW      = $clog2(MAX_DIM);
   localparam int RW      = 2 * CW;
   localparam int ROWS    = MAX_DIM * MAX_DIM;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);

   // Field widths and fixed-point formats.
   localparam int GRID_W     = 6;
   localparam int CS_W       = 8;
   localparam int VOX_W      = 5;
   localparam int COORD_W    = 23;
   localparam int COORD_FRAC = 8;
   localparam int DIR_W      = 16;
   localparam int DIR_FRAC   = 14;
   localparam int CELL_W     = 16;
   localparam int NUM_W      = 26;
   localparam int UNIT_W     = CS_W + COORD_FRAC;
   localparam int T_W        = 48;
   localparam int PROD_W     = T_W + DIR_W;

   // Serial divider sizing.
   localparam int DIV_W     = 40;
   localparam int DIVISOR_W = 16;
   localparam int DCNT_W    = $clog2(DIV_W + 1);

   localparam logic signed [T_W-1:0]    T_MAX = {1'b0, {(T_W - 1){1'b1}}};
   localparam logic signed [PROD_W-1:0] C_MAX = PROD_W'(64'sd4194303);
   localparam logic signed [PROD_W-1:0] C_MIN = -PROD_W'(64'sd4194304);

   // Operation codes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_CAST  = 1'b1;

   // Register indexes.
   localparam logic [1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [1:0] CSR_GRID_X    = 2'd1;
   localparam logic [1:0] CSR_GRID_Y    = 2'd2;
   localparam logic [1:0] CSR_GRID_Z    = 2'd3;

   localparam logic [1:0] AXIS_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_MERGE,
      ST_DIV_LOAD,
      ST_DIV_RUN,
      ST_NUM,
      ST_WALK,
      ST_FETCH,
      ST_PROBE,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_CELL,
      PH_TN,
      PH_TD
   } phase_type;

   // One access to the occupancy store: a row of MAX_DIM cells along z.
   typedef struct packed {
      logic          rd;
      logic          wr;
      logic [RW-1:0] row;
   } store_req_type;

   // Grid size clipped to the store's extent.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [GRID_W-1:0] g);
      if (int'(g) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return DIM_W'(g);
   endfunction

   // A cell index lies inside the configured grid along one axis.
   function automatic logic cell_inside(input logic signed [CELL_W-1:0] c,
                                        input logic [DIM_W-1:0] d);
      return !c[CELL_W-1] && (c[CELL_W-2:0] < (CELL_W - 1)'(d));
   endfunction

endpackage

// ----- src/vrt_divider.sv -----
`timescale 1ns / 1ps

module vrt_divider import vrt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_W-1:0]     quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DCNT_W-1:0]    cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [DIVISOR_W:0]   shifted;
   logic [DIVISOR_W:0]   diff;

   // One restoring step: bring down the next dividend bit and try a subtract.
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   // Control: one quotient bit per cycle, a done beat after the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DCNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: partial remainder and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W]) begin
            rem_ff <= diff[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DIVISOR_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/vrt_occ_store.sv -----
`timescale 1ns / 1ps

module vrt_occ_store import vrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  store_req_type      req,
   input  logic [MAX_DIM-1:0] wr_data,
   output logic               ready,
   output logic [MAX_DIM-1:0] rd_data
);

   logic [MAX_DIM-1:0] mem [ROWS];
   logic               clearing_ff;
   logic [RW-1:0]      clr_row_ff;
   logic [MAX_DIM-1:0] rd_data_ff;

   // Clearing pass after reset: one row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clearing_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == RW'(ROWS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Single write port, shared by the clearing pass and cell updates.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_row_ff] <= '0;
      end else if (req.wr) begin
         mem[req.row] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (req.rd) begin
         rd_data_ff <= mem[req.row];
      end
   end

   assign ready   = !clearing_ff;
   assign rd_data = rd_data_ff;

endmodule

// ----- src/voxel_ray_traversal_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  opcode, vox_x/y/z, occupied, start_x/y/z, dir_x/y/z
// rsp_      out        rsp_valid/rsp_stall  hit, hit_x/y/z (one beat per cast)
// csr_      in         csr_wr_en            csr_index, csr_data
//
// A write beat reads its row, merges the cell and writes the row back; one outside the grid is dropped.
// A cast first runs its setup in the serial divider (cell index, then first-boundary t and
// step t for each moving axis), then steps cell by cell with one store read each, and last forms the hit point.
// After reset the store's MAX_DIM * MAX_DIM = 1024 rows are swept clear, one row a cycle.
// req_stall is high while an item is in progress or the sweep runs; a finished result
// waits in the output register, so a new item is taken while rsp_stall holds it.

module voxel_ray_traversal_core import vrt_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_opcode,
   input  logic [VOX_W-1:0]          req_vox_x,
   input  logic [VOX_W-1:0]          req_vox_y,
   input  logic [VOX_W-1:0]          req_vox_z,
   input  logic                      req_occupied,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_start_z,
   input  logic signed [DIR_W-1:0]   req_dir_x,
   input  logic signed [DIR_W-1:0]   req_dir_y,
   input  logic signed [DIR_W-1:0]   req_dir_z,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_hit,
   output logic signed [COORD_W-1:0] rsp_hit_x,
   output logic signed [COORD_W-1:0] rsp_hit_y,
   output logic signed [COORD_W-1:0] rsp_hit_z,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [CS_W-1:0]           csr_data
);

   state_type state_ff, state_in;
   phase_type phase_ff;

   logic [CS_W-1:0]   cell_size_ff;
   logic [GRID_W-1:0] grid_x_ff, grid_y_ff, grid_z_ff;

   logic signed [COORD_W-1:0] st_ff   [3];
   logic signed [DIR_W-1:0]   dir_ff  [3];
   logic [2:0]                neg_ff;
   logic signed [CELL_W-1:0]  cell_ff [3];
   logic signed [T_W-1:0]     tn_ff   [3];
   logic signed [T_W-1:0]     td_ff   [3];
   logic signed [NUM_W-1:0]   num_ff;
   logic [1:0]                axis_ff;
   logic signed [T_W-1:0]     t_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic [RW-1:0]             wr_row_ff;
   logic [CW-1:0]             wr_bit_ff;
   logic                      wr_occ_ff;
   logic                      res_hit_ff;
   logic signed [COORD_W-1:0] res_p_ff [3];

   logic                      rsp_valid_ff;
   logic                      rsp_hit_ff;
   logic signed [COORD_W-1:0] rsp_p_ff [3];

   logic [DIM_W-1:0]  dim [3];
   logic [CS_W-1:0]   cs_eff;
   logic [UNIT_W-1:0] unit;
   logic              req_fire;
   logic              wr_in_grid;
   logic              inside_now;
   logic              last_axis;
   logic              rsp_load;

   logic signed [COORD_W-1:0] st_a;
   logic signed [DIR_W-1:0]   dir_a;
   logic signed [CELL_W-1:0]  cell_a;
   logic [COORD_W-1:0]        st_mag;
   logic [DIR_W-1:0]          dir_mag;
   logic [NUM_W-1:0]          num_mag;
   logic signed [CELL_W:0]    cell_adj;
   logic signed [35:0]        num_wide;
   logic signed [NUM_W-1:0]   num_in;
   logic [CELL_W-1:0]         q_cell;

   logic                 div_start;
   logic                 div_done;
   logic [DIV_W-1:0]     div_dividend;
   logic [DIVISOR_W-1:0] div_divisor;
   logic [DIV_W-1:0]     div_quotient;

   logic [1:0]              ax_sel;
   logic signed [T_W-1:0]   t_sel;
   logic signed [T_W:0]     t_sum;
   logic signed [T_W-1:0]   t_step;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] q_pt;
   logic signed [PROD_W-1:0] p_sum;
   logic signed [COORD_W-1:0] p_sat;

   store_req_type      store_req;
   logic               store_ready;
   logic [MAX_DIM-1:0] store_rd_data;
   logic [MAX_DIM-1:0] merged;
   logic               probe_bit;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cell_size_ff <= CS_W'(1);
         grid_x_ff    <= GRID_W'(32);
         grid_y_ff    <= GRID_W'(32);
         grid_z_ff    <= GRID_W'(32);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CELL_SIZE: cell_size_ff <= csr_data;
            CSR_GRID_X:    grid_x_ff    <= csr_data[GRID_W-1:0];
            CSR_GRID_Y:    grid_y_ff    <= csr_data[GRID_W-1:0];
            CSR_GRID_Z:    grid_z_ff    <= csr_data[GRID_W-1:0];
            default:       cell_size_ff <= cell_size_ff;
         endcase
      end
   end

   assign dim[0] = eff_dim(grid_x_ff);
   assign dim[1] = eff_dim(grid_y_ff);
   assign dim[2] = eff_dim(grid_z_ff);
   assign cs_eff = (cell_size_ff == '0) ? CS_W'(1) : cell_size_ff;
   assign unit   = {cs_eff, {COORD_FRAC{1'b0}}};

   assign req_stall = (state_ff != ST_IDLE) || !store_ready;
   assign req_fire  = req_valid && !req_stall;
   assign wr_in_grid = (int'(req_vox_x) < int'(dim[0])) &&
                       (int'(req_vox_y) < int'(dim[1])) &&
                       (int'(req_vox_z) < int'(dim[2]));

   assign inside_now = cell_inside(cell_ff[0], dim[0]) &&
                       cell_inside(cell_ff[1], dim[1]) &&
                       cell_inside(cell_ff[2], dim[2]);
   assign last_axis  = (axis_ff == AXIS_LAST);

   // Per-axis setup operands, selected by the axis counter.
   assign st_a    = st_ff[axis_ff];
   assign dir_a   = dir_ff[axis_ff];
   assign cell_a  = cell_ff[axis_ff];
   assign st_mag  = st_a[COORD_W-1] ? COORD_W'(-st_a) : COORD_W'(st_a);
   assign dir_mag = dir_a[DIR_W-1] ? DIR_W'(-dir_a) : DIR_W'(dir_a);
   assign num_mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign q_cell  = div_quotient[CELL_W-1:0];

   // Distance to the first cell boundary along the step direction.
   assign cell_adj = {cell_a[CELL_W-1], cell_a} +
                     (dir_a[DIR_W-1] ? (CELL_W + 1)'(0) : (CELL_W + 1)'(1));
   assign num_wide = cell_adj * $signed({1'b0, unit});
   assign num_in   = NUM_W'(num_wide - 36'(st_a));

   // Divider operands for each setup phase.
   always_comb begin
      case (phase_ff)
         PH_CELL: begin
            div_dividend = DIV_W'(st_mag >> COORD_FRAC);
            div_divisor  = DIVISOR_W'(cs_eff);
         end
         PH_TN: begin
            div_dividend = DIV_W'({num_mag, {DIR_FRAC{1'b0}}});
            div_divisor  = dir_mag;
         end
         default: begin
            div_dividend = DIV_W'({cs_eff, {(COORD_FRAC + DIR_FRAC){1'b0}}});
            div_divisor  = dir_mag;
         end
      endcase
   end

   vrt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Axis with the smallest t; ties go to z, then y.
   always_comb begin
      if (tn_ff[0] < tn_ff[1]) begin
         ax_sel = (tn_ff[0] < tn_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         ax_sel = (tn_ff[1] < tn_ff[2]) ? 2'd1 : 2'd2;
      end
   end

   // Saturating advance of the chosen axis.
   assign t_sel  = tn_ff[ax_sel];
   assign t_sum  = {t_sel[T_W-1], t_sel} + {td_ff[ax_sel][T_W-1], td_ff[ax_sel]};
   assign t_step = (t_sum > $signed({1'b0, T_MAX})) ? T_MAX : t_sum[T_W-1:0];

   // Hit point: start + t * dir / 2^14, truncated toward zero and saturated.
   assign prod_in = t_ff * dir_a;
   assign q_pt    = (prod_ff + (prod_ff[PROD_W-1] ? PROD_W'(16383) : PROD_W'(0)))
                    >>> DIR_FRAC;
   assign p_sum   = q_pt + PROD_W'(st_a);
   assign p_sat   = (p_sum > C_MAX) ? COORD_W'(C_MAX) :
                    (p_sum < C_MIN) ? COORD_W'(C_MIN) : p_sum[COORD_W-1:0];

   // Read-modify-write merge of one cell into its row.
   always_comb begin
      merged            = store_rd_data;
      merged[wr_bit_ff] = wr_occ_ff;
   end

   assign probe_bit = store_rd_data[cell_ff[2][CW-1:0]];

   vrt_occ_store u_store (
      .clock   (clock),
      .reset   (reset),
      .req     (store_req),
      .wr_data (merged),
      .ready   (store_ready),
      .rd_data (store_rd_data)
   );

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer state register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state, divider start and store requests.
   always_comb begin
      state_in      = state_ff;
      div_start     = 1'b0;
      store_req.rd  = 1'b0;
      store_req.wr  = 1'b0;
      store_req.row = wr_row_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_CAST) begin
                  state_in = ST_DIV_LOAD;
               end else if (wr_in_grid) begin
                  state_in = ST_WR_READ;
               end
            end
         end
         ST_WR_READ: begin
            store_req.rd = 1'b1;
            state_in     = ST_WR_MERGE;
         end
         ST_WR_MERGE: begin
            store_req.wr = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               case (phase_ff)
                  PH_CELL: state_in = ST_NUM;
                  PH_TN:   state_in = ST_DIV_LOAD;
                  default: state_in = last_axis ? ST_WALK : ST_DIV_LOAD;
               endcase
            end
         end
         ST_NUM: begin
            if (dir_a == '0) begin
               state_in = last_axis ? ST_WALK : ST_DIV_LOAD;
            end else begin
               state_in = ST_DIV_LOAD;
            end
         end
         ST_WALK: begin
            state_in = inside_now ? ST_FETCH : ST_DONE;
         end
         ST_FETCH: begin
            if (inside_now) begin
               store_req.rd  = 1'b1;
               store_req.row = {cell_ff[0][CW-1:0], cell_ff[1][CW-1:0]};
               state_in      = ST_PROBE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PROBE: begin
            state_in = probe_bit ? ST_MUL : ST_WALK;
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = last_axis ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Working registers of the cast and write sequences.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               st_ff[0]  <= req_start_x;
               st_ff[1]  <= req_start_y;
               st_ff[2]  <= req_start_z;
               dir_ff[0] <= req_dir_x;
               dir_ff[1] <= req_dir_y;
               dir_ff[2] <= req_dir_z;
               neg_ff    <= {req_dir_z[DIR_W-1], req_dir_y[DIR_W-1], req_dir_x[DIR_W-1]};
               axis_ff   <= 2'd0;
               phase_ff  <= PH_CELL;
               wr_row_ff <= {CW'(req_vox_x), CW'(req_vox_y)};
               wr_bit_ff <= CW'(req_vox_z);
               wr_occ_ff <= req_occupied;
            end
         end
         ST_DIV_RUN: begin
            if (div_done) begin
               case (phase_ff)
                  PH_CELL: begin
                     cell_ff[axis_ff] <= st_a[COORD_W-1] ? -q_cell : q_cell;
                  end
                  PH_TN: begin
                     tn_ff[axis_ff] <= (num_ff[NUM_W-1] ^ dir_a[DIR_W-1]) ?
                                       -T_W'(div_quotient) : T_W'(div_quotient);
                     phase_ff       <= PH_TD;
                  end
                  default: begin
                     td_ff[axis_ff] <= T_W'(div_quotient);
                     phase_ff       <= PH_CELL;
                     axis_ff        <= last_axis ? 2'd0 : axis_ff + 2'd1;
                  end
               endcase
            end
         end
         ST_NUM: begin
            num_ff <= num_in;
            if (dir_a == '0) begin
               tn_ff[axis_ff] <= T_MAX;
               td_ff[axis_ff] <= T_MAX;
               phase_ff       <= PH_CELL;
               axis_ff        <= last_axis ? 2'd0 : axis_ff + 2'd1;
            end else begin
               phase_ff <= PH_TN;
            end
         end
         ST_WALK: begin
            if (inside_now) begin
               t_ff          <= t_sel;
               tn_ff[ax_sel] <= t_step;
               for (int i = 0; i < 3; i++) begin
                  if (ax_sel == 2'(i)) begin
                     cell_ff[i] <= neg_ff[i] ? cell_ff[i] - 1'b1 : cell_ff[i] + 1'b1;
                  end
               end
            end else begin
               res_hit_ff <= 1'b0;
               for (int i = 0; i < 3; i++) begin
                  res_p_ff[i] <= '0;
               end
            end
         end
         ST_FETCH: begin
            if (!inside_now) begin
               res_hit_ff <= 1'b0;
               for (int i = 0; i < 3; i++) begin
                  res_p_ff[i] <= '0;
               end
            end
         end
         ST_PROBE: begin
            if (probe_bit) begin
               res_hit_ff <= 1'b1;
               axis_ff    <= 2'd0;
            end
         end
         ST_MUL: begin
            prod_ff <= prod_in;
         end
         ST_SUM: begin
            res_p_ff[axis_ff] <= p_sat;
            if (!last_axis) begin
               axis_ff <= axis_ff + 2'd1;
            end
         end
         default: begin
            num_ff <= num_ff;
         end
      endcase
   end

   // Output register: holds a result beat until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff  <= res_hit_ff;
         rsp_p_ff[0] <= res_p_ff[0];
         rsp_p_ff[1] <= res_p_ff[1];
         rsp_p_ff[2] <= res_p_ff[2];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign rsp_hit_x = rsp_p_ff[0];
   assign rsp_hit_y = rsp_p_ff[1];
   assign rsp_hit_z = rsp_p_ff[2];

   // The divider only reports a quotient while the sequencer waits for it.
   a_div_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_RUN))
      else $error("divider finished outside the wait state");

   // A result beat only appears after the sequencer has finished a cast.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result beat raised without a finished cast");

   // A miss carries a zero point.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |->
         (rsp_p_ff[0] == '0) && (rsp_p_ff[1] == '0) && (rsp_p_ff[2] == '0))
      else $error("miss with a non-zero point");

   // Every probe of a cell follows a store read in the previous cycle.
   a_probe_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> $past(store_req.rd))
      else $error("cell probed without a store read");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import vrt_pkg::*;

   localparam int  CYCLE_LIMIT = 4000000;
   localparam int  PHASES      = 10;
   localparam int  PHASE_ITEMS = 113;

   // One request beat as the sender offers it.
   typedef struct {
      logic                      op;
      logic [VOX_W-1:0]          vox[3];
      logic                      occ;
      logic signed [COORD_W-1:0] start[3];
      logic signed [DIR_W-1:0]   dir[3];
   } ray_item_type;

   // One result beat: the hit flag and the hit point.
   typedef struct {
      logic                      hit;
      logic signed [COORD_W-1:0] pos[3];
   } hit_result_type;

   // Mirror of the occupancy grid and registers, with the casts still owed.
   class voxel_scoreboard;
      bit             occ_store[MAX_DIM * MAX_DIM * MAX_DIM];
      int unsigned    cell_sz;
      int unsigned    grid[3];
      hit_result_type owed_hits[$];
      int             errors;

      function new();
         cell_sz = 1;
         grid[0] = 32;
         grid[1] = 32;
         grid[2] = 32;
         errors  = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [CS_W-1:0] val);
         case (idx)
            CSR_CELL_SIZE: cell_sz = val;
            CSR_GRID_X: grid[0] = val & 8'h3F;
            CSR_GRID_Y: grid[1] = val & 8'h3F;
            CSR_GRID_Z: grid[2] = val & 8'h3F;
            default: cell_sz = cell_sz;
         endcase
      endfunction

      function bit in_grid(longint c[3], longint dm[3]);
         for (int i = 0; i < 3; i++) begin
            if (c[i] < 0 || c[i] >= dm[i]) return 0;
         end
         return 1;
      endfunction

      function longint clamp_t(longint v);
         longint tmax;
         tmax = 64'h7FFF_FFFF_FFFF;
         if (v > tmax) return tmax;
         if (v < -tmax - 1) return -tmax - 1;
         return v;
      endfunction

      // Apply a write, or walk a cast through the grid and queue its outcome.
      function void note_item(ray_item_type it);
         longint         unit, t, p;
         longint         dm[3], c[3], st[3], dr[3], tn[3], td[3], sp[3];
         int             ax;
         hit_result_type r;
         unit = longint'(cell_sz == 0 ? 1 : cell_sz) * 256;
         for (int i = 0; i < 3; i++) dm[i] = grid[i] > MAX_DIM ? MAX_DIM : grid[i];
         if (it.op == OP_WRITE) begin
            for (int i = 0; i < 3; i++) c[i] = it.vox[i];
            if (in_grid(c, dm)) occ_store[(c[0] * MAX_DIM + c[1]) * MAX_DIM + c[2]] = it.occ;
            return;
         end
         for (int i = 0; i < 3; i++) begin
            st[i] = it.start[i];
            dr[i] = it.dir[i];
            c[i]  = st[i] / unit;
            sp[i] = dr[i] < 0 ? -1 : 1;
            if (dr[i] == 0) begin
               tn[i] = 64'h7FFF_FFFF_FFFF;
               td[i] = 64'h7FFF_FFFF_FFFF;
            end else begin
               tn[i] = clamp_t(((c[i] + (sp[i] > 0 ? 1 : 0)) * unit - st[i]) * 16384 / dr[i]);
               td[i] = clamp_t(unit * 16384 / (dr[i] < 0 ? -dr[i] : dr[i]));
            end
         end
         r.hit = 0;
         for (int i = 0; i < 3; i++) r.pos[i] = '0;
         while (in_grid(c, dm)) begin
            // Smallest t wins; ties go to z, then y.
            if (tn[0] < tn[1]) ax = tn[0] < tn[2] ? 0 : 2;
            else ax = tn[1] < tn[2] ? 1 : 2;
            t      = tn[ax];
            tn[ax] = clamp_t(tn[ax] + td[ax]);
            c[ax]  = c[ax] + sp[ax];
            if (in_grid(c, dm) && occ_store[(c[0] * MAX_DIM + c[1]) * MAX_DIM + c[2]]) begin
               r.hit = 1;
               for (int i = 0; i < 3; i++) begin
                  p = st[i] + (t * dr[i]) / 16384;
                  if (p > 4194303) p = 4194303;
                  if (p < -4194304) p = -4194304;
                  r.pos[i] = p[COORD_W-1:0];
               end
               break;
            end
         end
         owed_hits.push_back(r);
      endfunction

      function void check_result(hit_result_type got);
         hit_result_type want;
         string          names[3];
         names = '{"hit_x", "hit_y", "hit_z"};
         if (owed_hits.size() == 0) begin
            $error("result beat with no cast outstanding");
            errors++;
            return;
         end
         want = owed_hits.pop_front();
         if (got.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, got.hit);
            errors++;
         end
         for (int i = 0; i < 3; i++) begin
            if (got.pos[i] !== want.pos[i]) begin
               $error("%s: expected %0d, got %0d", names[i], want.pos[i], got.pos[i]);
               errors++;
            end
         end
      endfunction
   endclass

   logic                      clock = 0;
   logic                      reset;
   logic                      req_valid, req_stall, req_opcode, req_occupied;
   logic [VOX_W-1:0]          req_vox_x, req_vox_y, req_vox_z;
   logic signed [COORD_W-1:0] req_start_x, req_start_y, req_start_z;
   logic signed [DIR_W-1:0]   req_dir_x, req_dir_y, req_dir_z;
   logic                      rsp_valid, rsp_stall, rsp_hit;
   logic signed [COORD_W-1:0] rsp_hit_x, rsp_hit_y, rsp_hit_z;
   logic                      csr_wr_en;
   logic [1:0]                csr_index;
   logic [CS_W-1:0]           csr_data;

   voxel_scoreboard sb = new();
   int unsigned     cycles = 0;

   voxel_ray_traversal_core uut (.*);

   always #1 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      hit_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.hit    = rsp_hit;
         got.pos[0] = rsp_hit_x;
         got.pos[1] = rsp_hit_y;
         got.pos[2] = rsp_hit_z;
         sb.check_result(got);
      end
   end

   // Receiver: segments of varying stall density, and one long hold-off.
   initial begin
      int hold_at, seg, pct;
      hold_at = 30000;
      rsp_stall <= 1'b0;
      forever begin
         seg = $urandom_range(20, 300);
         case ($urandom_range(0, 3))
            0: pct = 0;
            1: pct = 25;
            2: pct = 60;
            default: pct = 90;
         endcase
         repeat (seg) begin
            @(posedge clock);
            hold_at--;
            if (hold_at == 0) begin
               rsp_stall <= 1'b1;
               repeat (5000) @(posedge clock);
            end
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   // Offer one beat and hold it until the block takes it.
   task automatic send_item(ray_item_type it);
      req_valid    <= 1'b1;
      req_opcode   <= it.op;
      req_vox_x    <= it.vox[0];
      req_vox_y    <= it.vox[1];
      req_vox_z    <= it.vox[2];
      req_occupied <= it.occ;
      req_start_x  <= it.start[0];
      req_start_y  <= it.start[1];
      req_start_z  <= it.start[2];
      req_dir_x    <= it.dir[0];
      req_dir_y    <= it.dir[1];
      req_dir_z    <= it.dir[2];
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
   endtask

   task automatic pause(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic write_cell(int x, int y, int z, bit occ);
      ray_item_type it;
      it       = '{default: '0, vox: '{default: '0}, start: '{default: '0}, dir: '{default: '0}};
      it.op    = OP_WRITE;
      it.vox   = '{VOX_W'(x), VOX_W'(y), VOX_W'(z)};
      it.occ   = occ;
      send_item(it);
   endtask

   task automatic cast_ray(int sx, int sy, int sz, int dx, int dy, int dz);
      ray_item_type it;
      it       = '{default: '0, vox: '{default: '0}, start: '{default: '0}, dir: '{default: '0}};
      it.op    = OP_CAST;
      it.start = '{COORD_W'(sx), COORD_W'(sy), COORD_W'(sz)};
      it.dir   = '{DIR_W'(dx), DIR_W'(dy), DIR_W'(dz)};
      send_item(it);
   endtask

   // Registers change only once every cast has answered and the block is free.
   task automatic set_config(int cs, int gx, int gy, int gz);
      int vals[4];
      vals = '{cs, gx, gy, gz};
      pause(1);
      while (sb.owed_hits.size() != 0) @(posedge clock);
      do @(posedge clock); while (req_stall);
      repeat (8) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[1:0];
         csr_data  <= vals[i][CS_W-1:0];
         sb.set_reg(i[1:0], vals[i][CS_W-1:0]);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_grid();
      case ($urandom_range(0, 9))
         0: return 1;
         1: return 32;
         2: return $urandom_range(33, 63);
         3, 4: return $urandom_range(1, 32);
         default: return $urandom_range(2, 6);
      endcase
   endfunction

   // Stimulus.
   initial begin
      int           cs, unit, burst;
      int           g[3], dm[3];
      ray_item_type it;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_opcode   <= OP_WRITE;
      req_vox_x    <= '0;
      req_vox_y    <= '0;
      req_vox_z    <= '0;
      req_occupied <= 1'b0;
      req_start_x  <= '0;
      req_start_y  <= '0;
      req_start_z  <= '0;
      req_dir_x    <= '0;
      req_dir_y    <= '0;
      req_dir_z    <= '0;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_CELL_SIZE;
      csr_data     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed beats at the reset settings: unit cells, full grid.
      set_config(1, 32, 32, 32);
      write_cell(1, 0, 0, 1);
      cast_ray(128, 128, 128, 16384, 0, 0);
      write_cell(0, 0, 0, 1);
      write_cell(31, 31, 31, 1);
      write_cell(1, 1, 1, 1);
      // Equal components: the tie steps z first, then y, then x.
      cast_ray(128, 128, 128, 16384, 16384, 16384);
      cast_ray(7900, 7900, 7900, -32768, -32768, -32768);
      cast_ray(128, 128, 128, 0, 0, 0);
      cast_ray(4194303, 4194303, 4194303, -32768, 0, 0);
      cast_ray(-4194304, -4194304, -4194304, 32767, 32767, 32767);
      cast_ray(-100, 128, 128, 32767, 0, 0);
      cast_ray(7935, 7935, 7935, -1, -1, -32768);
      write_cell(1, 0, 0, 0);
      cast_ray(128, 128, 128, 16384, 0, 0);
      // Small grid: writes outside it are dropped, casts from outside miss.
      set_config(255, 2, 2, 2);
      write_cell(5, 0, 0, 1);
      write_cell(0, 1, 0, 1);
      cast_ray(100, 100, 100, 0, 32767, 0);
      cast_ray(300000, 100, 100, -32768, 0, 0);
      // Zero cell size and an empty grid.
      set_config(0, 0, 0, 0);
      write_cell(0, 0, 0, 1);
      cast_ray(128, 128, 128, 16384, 0, 0);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: cs = 255;
            1: cs = 0;
            2: cs = 1;
            default: cs = $urandom_range(1, 255);
         endcase
         for (int i = 0; i < 3; i++) g[i] = (ph == 4 && i == 1) ? 0 : pick_grid();
         set_config(cs, g[0], g[1], g[2]);
         unit = (cs == 0 ? 1 : cs) * 256;
         for (int i = 0; i < 3; i++) dm[i] = g[i] > 32 ? 32 : g[i];
         burst = 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (burst == 0) begin
               pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
               burst = $urandom_range(1, 8);
            end
            burst--;
            it = '{default: '0, vox: '{default: '0}, start: '{default: '0},
                   dir: '{default: '0}};
            if ($urandom_range(0, 99) < 55) begin
               it.op  = OP_WRITE;
               it.occ = $urandom_range(0, 3) != 0;
               for (int i = 0; i < 3; i++)
                  it.vox[i] = VOX_W'((dm[i] > 0 && $urandom_range(0, 99) < 85)
                              ? $urandom_range(0, dm[i] - 1) : $urandom_range(0, 31));
            end else begin
               it.op = OP_CAST;
               for (int i = 0; i < 3; i++) begin
                  case ($urandom_range(0, 9))
                     0: it.start[i] = COORD_W'(-int'($urandom_range(0, unit - 1)));
                     1: it.start[i] = COORD_W'($urandom);
                     default:
                        it.start[i] = COORD_W'((dm[i] > 0 ? $urandom_range(0, dm[i] - 1) : 0)
                                      * unit + $urandom_range(0, unit - 1));
                  endcase
                  case ($urandom_range(0, 9))
                     0: it.dir[i] = '0;
                     1: it.dir[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                     2: it.dir[i] = DIR_W'(int'($urandom_range(0, 127)) - 64);
                     default: it.dir[i] = DIR_W'($urandom);
                  endcase
               end
            end
            send_item(it);
         end
      end

      // Drain, then allow the last beat to settle.
      pause(1);
      while (sb.owed_hits.size() != 0) @(posedge clock);
      repeat (1000) @(posedge clock);
      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
